// File: sv/led64_block_decrypt_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LED-64 block decrypter
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LED64_BLOCK_DECRYPT_ASSERT_SVH
`define LED64_BLOCK_DECRYPT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/led64_pkg.sv
// ----------------------------------------------------------------------------
// LED-64 decrypt package
// Word types, tables and nibble-level helper functions.
// ----------------------------------------------------------------------------
package led64_pkg;
    localparam int ROUNDS = 32;
    localparam int NCELLS = ROUNDS - 1;

    typedef struct packed {
        logic [63:0] cipher_block;
        logic        last_block;
    } t_in_word;

    typedef struct packed {
        logic [63:0] plain_block;
        logic        last_block_out;
    } t_out_word;

    typedef struct packed {
        logic [63:0] state;
        logic        last;
    } t_cell_data;

    function automatic logic [3:0] inv_sbox(input logic [3:0] v);
        logic [3:0] r;
        case (v)
            4'h0: r = 4'h5; 4'h1: r = 4'hE; 4'h2: r = 4'hF; 4'h3: r = 4'h8;
            4'h4: r = 4'hC; 4'h5: r = 4'h1; 4'h6: r = 4'h2; 4'h7: r = 4'hD;
            4'h8: r = 4'hB; 4'h9: r = 4'h4; 4'hA: r = 4'h6; 4'hB: r = 4'h3;
            4'hC: r = 4'h0; 4'hD: r = 4'h7; 4'hE: r = 4'h9; default: r = 4'hA;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] r;
        logic [3:0] x;
        r = 4'h0;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) r = r ^ x;
            x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [3:0] mat(input int r, input int j);
        logic [15:0] row;
        case (r)
            0: row = 16'hCCD4;
            1: row = 16'h3845;
            2: row = 16'h762E;
            default: row = 16'hD99D;
        endcase
        return row[15-4*j -: 4];
    endfunction

    // Inverse MixColumns with shifted row placement, optional inverse S-box.
    function automatic logic [63:0] mix(input logic [63:0] s, input logic with_sbox);
        logic [63:0] t;
        logic [3:0]  acc;
        logic [3:0]  v;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 4'h0;
                for (int j = 0; j < 4; j++) begin
                    v = s[4*(c+4*j) +: 4];
                    if (with_sbox) v = inv_sbox(v);
                    acc = acc ^ gf_mul(mat(r, j), v);
                end
                t[4*(r*4 + ((c + r) & 3)) +: 4] = acc;
            end
        end
        return t;
    endfunction

    // Transformed round constants for nibbles 1, 6, 11, 12.
    function automatic logic [15:0] rc_tab(input logic [4:0] rd);
        logic [15:0] r;
        case (rd)
            5'd0:  r = 16'h0101; 5'd1:  r = 16'hB4BC; 5'd2:  r = 16'hD5DF;
            5'd3:  r = 16'hC28B; 5'd4:  r = 16'hEC23; 5'd5:  r = 16'h2ED4;
            5'd6:  r = 16'h9A68; 5'd7:  r = 16'hC233; 5'd8:  r = 16'hB404;
            5'd9:  r = 16'h8DF8; 5'd10: r = 16'h61A7; 5'd11: r = 16'h17EC;
            5'd12: r = 16'hFB0B; 5'd13: r = 16'hD567; 5'd14: r = 16'h9AAC;
            5'd15: r = 16'h4F0F; 5'd16: r = 16'hD51B; 5'd17: r = 16'h4FB7;
            5'd18: r = 16'h8D3C; 5'd19: r = 16'hEC9B; 5'd20: r = 16'h76F3;
            5'd21: r = 16'h3944; 5'd22: r = 16'h39FC; 5'd23: r = 16'h61DB;
            5'd24: r = 16'hC2F7; 5'd25: r = 16'h3938; 5'd26: r = 16'hECE7;
            5'd27: r = 16'hA3E8; 5'd28: r = 16'hFB77; 5'd29: r = 16'h007C;
            5'd30: r = 16'h589F; default: r = 16'h768F;
        endcase
        return r;
    endfunction
endpackage

// File: sv/led64_block_decrypt.sv
// ----------------------------------------------------------------------------
// LED-64 block decrypter
// Fully unrolled ECB decryption, one round cell per round from 31 down to 1.
// ----------------------------------------------------------------------------
// Usage: write the 64-bit key through i_key_we/i_key_wdata while the block is
// idle. Input words arrive on i_in_valid/i_in_word and are taken at an edge
// where o_in_stall is low. Each word passes an input register that applies
// the key whitening and inverse mixing, then a chain of 31 round cells
// (rounds 31 down to 1), then an output register that applies the final
// inverse S-box, round-0 constants and key. One word is accepted every cycle
// while the output stage is not both full and stalled.
// The chain moves as one: when the receiver stalls a held output word, every
// stage holds, and the input is stalled exactly when the output stage is full
// and stalled. Empty stages are not squeezed out; they travel with the chain.
// Reset clears all valid bits and the key register; data registers keep no
// reset value.
// ----------------------------------------------------------------------------
`include "led64_block_decrypt_assert.svh"
module led64_block_decrypt
    import led64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_key_we,
    input  logic [63:0] i_key_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);
    logic [63:0] r_key;
    logic [63:0] r_mkey;
    logic        adv;

    // The mixed key is recomputed registered whenever the key changes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mkey <= '0;
        end else begin
            if (i_key_we) r_key <= i_key_wdata;
            r_mkey <= mix(r_key, 1'b0);
        end
    end

    logic       r_out_valid;
    t_out_word  r_out;
    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    logic       r_pre_valid;
    t_cell_data r_pre;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (adv) begin
            r_pre_valid <= i_in_valid;
        end
        if (adv) begin
            r_pre.state <= mix(i_in_word.cipher_block ^ r_key, 1'b0);
            r_pre.last  <= i_in_word.last_block;
        end
    end

    logic       v_chain [NCELLS+1];
    t_cell_data d_chain [NCELLS+1];
    assign v_chain[0] = r_pre_valid;
    assign d_chain[0] = r_pre;

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        led64_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (5'(NCELLS - g)),
            .i_mkey  (r_mkey),
            .i_adv   (adv),
            .i_valid (v_chain[g]),
            .i_data  (d_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_data  (d_chain[g+1])
        );
    end

    logic [63:0] fin;
    logic [15:0] rc0;
    always_comb begin
        rc0 = rc_tab(5'd0);
        for (int k = 0; k < 16; k++) fin[4*k +: 4] = inv_sbox(d_chain[NCELLS].state[4*k +: 4]);
        fin[3:0]   = fin[3:0]   ^ 4'h4;
        fin[19:16] = fin[19:16] ^ 4'h5;
        fin[35:32] = fin[35:32] ^ 4'h2;
        fin[51:48] = fin[51:48] ^ 4'h3;
        fin[7:4]   = fin[7:4]   ^ rc0[15:12];
        fin[23:20] = fin[23:20] ^ rc0[11:8];
        fin[39:36] = fin[39:36] ^ rc0[7:4];
        fin[55:52] = fin[55:52] ^ rc0[3:0];
        fin = fin ^ r_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= v_chain[NCELLS];
        end
        if (adv) begin
            r_out.plain_block    <= fin;
            r_out.last_block_out <= d_chain[NCELLS].last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_in_stall, r_out_valid)
    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))
    `ASSERT_NEXT(a_pre_fill, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_pre_valid)
endmodule

// File: sv/led64_round_cell.sv
// ----------------------------------------------------------------------------
// LED-64 decrypt round cell
// One registered inverse round; the round number is fixed per cell.
// ----------------------------------------------------------------------------
module led64_round_cell
    import led64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_round,
    input  logic [63:0] i_mkey,
    input  logic        i_adv,
    input  logic        i_valid,
    input  t_cell_data  i_data,
    output logic        o_valid,
    output t_cell_data  o_data
);
    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic [15:0] rc;

    always_comb begin
        rc = rc_tab(i_round);
        n_data = i_data;
        n_data.state = mix(i_data.state, 1'b1);
        n_data.state[3:0]   = n_data.state[3:0]   ^ 4'h9;
        n_data.state[23:20] = n_data.state[23:20] ^ 4'h5;
        n_data.state[43:40] = n_data.state[43:40] ^ 4'h7;
        n_data.state[63:60] = n_data.state[63:60] ^ 4'hF;
        n_data.state[7:4]   = n_data.state[7:4]   ^ rc[15:12];
        n_data.state[27:24] = n_data.state[27:24] ^ rc[11:8];
        n_data.state[47:44] = n_data.state[47:44] ^ rc[7:4];
        n_data.state[51:48] = n_data.state[51:48] ^ rc[3:0];
        if (i_round[1:0] == 2'b00) n_data.state = n_data.state ^ i_mkey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// LED-64 block decrypter testbench
// Drives ciphertext words under a series of keys, predicts each plaintext
// with an independent nibble-level model and checks every output word in
// order, under random sender gaps, receiver stalls and a long hold-off.
// ----------------------------------------------------------------------------
module tb_top
    import led64_pkg::*;
();

    localparam int LATENCY = 33;
    localparam int N_RANDOM = 900;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_key_we = 1'b0;
    logic [63:0] i_key_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;

    led64_block_decrypt i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_we    (i_key_we),
        .i_key_wdata (i_key_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // Words waiting for the driver, and plaintexts waiting for the monitor.
    t_in_word  pending_words[$];
    t_out_word plain_expected[$];
    logic [63:0] cur_key = '0;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    bit in_taken = 1'b0;

    // The substitution and mixing constants of the cipher, held as tables.
    logic [3:0] sbox_inv[16] = '{4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
                                 4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA};
    logic [3:0] mix_rows[4][4] = '{'{4'hC, 4'hC, 4'hD, 4'h4},
                                   '{4'h3, 4'h8, 4'h4, 4'h5},
                                   '{4'h7, 4'h6, 4'h2, 4'hE},
                                   '{4'hD, 4'h9, 4'h9, 4'hD}};
    logic [15:0] round_const[32] = '{
        16'h0101, 16'hB4BC, 16'hD5DF, 16'hC28B, 16'hEC23, 16'h2ED4, 16'h9A68, 16'hC233,
        16'hB404, 16'h8DF8, 16'h61A7, 16'h17EC, 16'hFB0B, 16'hD567, 16'h9AAC, 16'h4F0F,
        16'hD51B, 16'h4FB7, 16'h8D3C, 16'hEC9B, 16'h76F3, 16'h3944, 16'h39FC, 16'h61DB,
        16'hC2F7, 16'h3938, 16'hECE7, 16'hA3E8, 16'hFB77, 16'h007C, 16'h589F, 16'h768F};

    // Multiplication in GF(16) modulo x^4+x+1, done by shift and add.
    function automatic logic [3:0] gf16_times(logic [3:0] a, logic [3:0] b);
        logic [4:0] x;
        logic [3:0] p;
        x = {1'b0, a};
        p = '0;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p ^= x[3:0];
            x = x << 1;
            if (x[4]) x ^= 5'h13;
        end
        return p;
    endfunction

    // Column mixing; row r of the result is rotated by r nibbles.
    function automatic logic [15:0] [3:0] mix_cols(logic [3:0] st[16], bit use_sbox);
        logic [3:0] res[16];
        logic [3:0] acc, v;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = '0;
                for (int j = 0; j < 4; j++) begin
                    v = st[c + 4 * j];
                    if (use_sbox) v = sbox_inv[v];
                    acc ^= gf16_times(mix_rows[r][j], v);
                end
                res[r * 4 + ((c + r) & 3)] = acc;
            end
        end
        return {>>{res}};
    endfunction

    function automatic t_out_word decrypt_block(logic [63:0] key, t_in_word w);
        logic [3:0] st[16], k0[16], km[16];
        logic [15:0] [3:0] tmp;
        logic [15:0] rc;
        t_out_word o;
        for (int k = 0; k < 16; k++) begin
            st[k] = w.cipher_block[4*k +: 4] ^ key[4*k +: 4];
            k0[k] = key[4*k +: 4];
        end
        tmp = mix_cols(k0, 0);
        for (int k = 0; k < 16; k++) km[k] = tmp[15-k];
        tmp = mix_cols(st, 0);
        for (int k = 0; k < 16; k++) st[k] = tmp[15-k];
        for (int rd = 31; rd > 0; rd--) begin
            rc = round_const[rd];
            tmp = mix_cols(st, 1);
            for (int k = 0; k < 16; k++) st[k] = tmp[15-k];
            st[0] ^= 4'h9; st[5] ^= 4'h5; st[10] ^= 4'h7; st[15] ^= 4'hF;
            st[1] ^= rc[15:12]; st[6] ^= rc[11:8]; st[11] ^= rc[7:4]; st[12] ^= rc[3:0];
            if ((rd & 3) == 0)
                for (int k = 0; k < 16; k++) st[k] ^= km[k];
        end
        for (int k = 0; k < 16; k++) st[k] = sbox_inv[st[k]];
        st[0] ^= 4'h4; st[4] ^= 4'h5; st[8] ^= 4'h2; st[12] ^= 4'h3;
        st[1] ^= round_const[0][15:12]; st[5] ^= round_const[0][11:8];
        st[9] ^= round_const[0][7:4]; st[13] ^= round_const[0][3:0];
        for (int k = 0; k < 16; k++) o.plain_block[4*k +: 4] = st[k] ^ k0[k];
        o.last_block_out = w.last_block;
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Driver: offers the oldest pending word, holding it until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= pending_words[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a long hold-off lets the pipeline fill and back up the input.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Monitor: compare each accepted output word with the oldest prediction,
    // and record the prediction for a word accepted at this edge. The key
    // only changes while the block is empty.
    always @(posedge i_clk) begin
        t_out_word want;
        in_taken = 1'b0;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (plain_expected.size() == 0) begin
                $error("unexpected output word %h", o_out_word);
                errors++;
            end else begin
                want = plain_expected.pop_front();
                if (o_out_word.plain_block !== want.plain_block) begin
                    $error("plain_block expected %h actual %h",
                           want.plain_block, o_out_word.plain_block);
                    errors++;
                end
                if (o_out_word.last_block_out !== want.last_block_out) begin
                    $error("last_block_out expected %b actual %b",
                           want.last_block_out, o_out_word.last_block_out);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            plain_expected.push_back(decrypt_block(cur_key, i_in_word));
            void'(pending_words.pop_front());
            in_taken = 1'b1;
        end
    end

    // Queues a word for the driver and returns at once.
    task automatic send_word(logic [63:0] blk, logic last);
        t_in_word w;
        w.cipher_block = blk;
        w.last_block = last;
        pending_words.push_back(w);
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || plain_expected.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Keys are only loaded with the block empty.
    task automatic load_key(logic [63:0] k);
        @(negedge i_clk);
        i_key_we <= 1'b1;
        i_key_wdata <= k;
        cur_key = k;
        @(negedge i_clk);
        i_key_we <= 1'b0;
    endtask

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: send_word({$urandom_range(1) ? 32'hFFFFFFFF : 32'h0, $urandom},
                             1'($urandom_range(1)));
                default: send_word(rand64(), 1'($urandom_range(1)));
            endcase
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset key of zero, the all-ones key, then a third key.
        send_word(64'h0, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'h0123_4567_89AB_CDEF, 1'b0);
        send_word(64'h8000_0000_0000_0001, 1'b1);
        send_word(64'hAAAA_5555_AAAA_5555, 1'b0);
        drain();
        load_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_word(64'h0, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'hFEDC_BA98_7654_3210, 1'b1);
        drain();
        load_key(64'h0123_4567_89AB_CDEF);
        for (int i = 0; i < 16; i++) send_word(64'hF << (4 * i), i[0]);
        drain();

        // Random part: three random keys, one per idling profile, then the zero key.
        send_idle_pct = 28; recv_idle_pct = 69;
        load_key(rand64());
        random_batch(N_RANDOM / 3);
        drain();
        send_idle_pct = 69; recv_idle_pct = 28;
        load_key(rand64());
        random_batch(N_RANDOM / 3);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        load_key(rand64());
        hold_cycles = 120;
        random_batch(N_RANDOM / 3);
        drain();
        load_key(64'h0);
        random_batch(20);
        drain();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule
